/* src/srpc_pkg.sv */
package srpc_pkg;

  localparam int unsigned COUNT_W = 11;
  localparam logic [COUNT_W-1:0] COUNT_SAT = '1;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] value;
    logic [15:0] range_low;
    logic [15:0] range_high;
  } cmd_t;

  typedef struct packed {
    logic [COUNT_W-1:0] prime_count;
    logic               bounds_found;
  } res_t;

endpackage

/* src/srpc_ram.sv */
module srpc_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 1024
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                       wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

/* src/sorted_range_prime_counter.sv */
// Channel   | Direction | Handshake                 | Payload
// ----------+-----------+---------------------------+-------------------
// command   | in        | start high, busy low      | cmd_i (cmd_t)
// result    | out       | result_valid_o, one cycle | result_o (res_t)
//
// After reset the block is busy for the sieve: it fills the prime bitmap,
// then for each sieving base reads its bitmap bit and, if the base is prime,
// makes one bitmap write per composite mark from the base's square upward.
// Clear and append leave busy low.
// A query runs two binary searches over the stored values and checks both
// bounds; if both are found it streams the span, one element per cycle,
// through the store -> bitmap read chain, then hands off the result. The
// value store has a single read port, so its reads go one at a time.
// The receiver cannot stall: each result shows for exactly one cycle.
module sorted_range_prime_counter #(
  parameter int unsigned MAX_VALUE  = 65535,
  parameter int unsigned DATA_DEPTH = 1024
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  srpc_pkg::cmd_t  cmd_i,
  output logic            result_valid_o,
  output srpc_pkg::res_t  result_o
);

  import srpc_pkg::*;

  localparam int unsigned MapDepth = MAX_VALUE + 1;
  localparam int unsigned MW = $clog2(MapDepth);
  localparam int unsigned SW = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;
  localparam int unsigned CW = $clog2(DATA_DEPTH + 1);
  localparam int unsigned VW = (MW > 16) ? MW : 16;
  localparam logic [MW-1:0] MaxIdx  = MW'(MAX_VALUE);
  localparam logic [MW:0]   MaxWide = (MW+1)'(MAX_VALUE);
  localparam logic [VW-1:0] MaxVal  = VW'(MAX_VALUE);
  localparam logic [CW-1:0] DepthC  = CW'(DATA_DEPTH);

  typedef enum logic [3:0] {
    ST_FILL, ST_SV_RD, ST_SV_WAIT, ST_SV_MARK, ST_IDLE,
    ST_LO_REQ, ST_LO_CMP, ST_UP_REQ, ST_UP_CMP,
    ST_FL_LO, ST_FL_HI, ST_FL_CHK, ST_WALK
  } state_e;

  state_e          state_q;
  cmd_t            cmd_q;
  logic [MW-1:0]   fill_q;
  logic [MW-1:0]   base_q;
  logic [MW:0]     sq_q;
  logic [MW:0]     mark_q;
  logic [CW-1:0]   count_q;
  logic [CW-1:0]   lo_q, hi_q, mid_q;
  logic [CW-1:0]   first_q, after_q, ptr_q;
  logic            found_lo_q;
  logic            s1_vld_q, s2_vld_q;
  logic [COUNT_W-1:0] primes_q;
  logic            rvld_q;
  res_t            res_q;

  // bitmap port
  logic            map_we;
  logic [MW-1:0]   map_waddr, map_raddr;
  logic            map_wdata, map_rdata;
  // value store port
  logic            st_we;
  logic [SW-1:0]   st_raddr;
  logic [15:0]     st_rdata;

  logic            accept;
  logic [CW:0]     mid_sum;
  logic [CW-1:0]   mid_c;
  logic [MW:0]     sq_next, mark_next;
  logic [VW-1:0]   elem_w;
  logic            elem_ok;
  logic            walk_issue;
  logic [CW-1:0]   after_m1;

  assign accept     = start && (state_q == ST_IDLE);
  assign mid_sum    = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid_c      = mid_sum[CW:1];
  assign sq_next    = sq_q + {base_q, 1'b1} + (MW+1)'(0);
  assign mark_next  = mark_q + {1'b0, base_q};
  assign elem_w     = VW'(st_rdata);
  assign elem_ok    = elem_w <= MaxVal;
  assign walk_issue = ptr_q < after_q;
  assign after_m1   = after_q - CW'(1);

  always_comb begin
    map_we    = 1'b0;
    map_waddr = fill_q;
    map_wdata = fill_q >= MW'(2);
    map_raddr = elem_w[MW-1:0];
    st_raddr  = mid_q[SW-1:0];
    unique case (state_q)
      ST_FILL:    map_we = 1'b1;
      ST_SV_RD:   map_raddr = base_q;
      ST_SV_MARK: begin
        map_we    = 1'b1;
        map_waddr = mark_q[MW-1:0];
        map_wdata = 1'b0;
      end
      // issue the probe read with the new midpoint so it lands in the compare
      ST_LO_REQ:  st_raddr = mid_c[SW-1:0];
      ST_UP_REQ:  st_raddr = mid_c[SW-1:0];
      ST_FL_LO:   st_raddr = first_q[SW-1:0];
      ST_FL_HI:   st_raddr = after_m1[SW-1:0];
      ST_WALK:    st_raddr = ptr_q[SW-1:0];
      default: ;
    endcase
  end

  assign st_we = accept && (cmd_i.operation == OP_APPEND) && (count_q < DepthC);

  srpc_ram #(.Width(1), .Depth(MapDepth)) u_map (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .raddr_i (map_raddr),
    .rdata_o (map_rdata)
  );

  srpc_ram #(.Width(16), .Depth(DATA_DEPTH)) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (count_q[SW-1:0]),
    .wdata_i (cmd_i.value),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_FILL;
      cmd_q      <= '0;
      fill_q     <= '0;
      base_q     <= MW'(2);
      sq_q       <= (MW+1)'(4);
      mark_q     <= '0;
      count_q    <= '0;
      lo_q       <= '0;
      hi_q       <= '0;
      mid_q      <= '0;
      first_q    <= '0;
      after_q    <= '0;
      ptr_q      <= '0;
      found_lo_q <= 1'b0;
      s1_vld_q   <= 1'b0;
      s2_vld_q   <= 1'b0;
      primes_q   <= '0;
      rvld_q     <= 1'b0;
      res_q      <= '0;
    end else begin
      rvld_q <= 1'b0;
      unique case (state_q)
        // write the initial bitmap: 0 and 1 not prime, all else candidate
        ST_FILL: begin
          fill_q <= fill_q + MW'(1);
          if (fill_q == MaxIdx) begin
            state_q <= (sq_q > MaxWide) ? ST_IDLE : ST_SV_RD;
          end
        end
        ST_SV_RD: state_q <= ST_SV_WAIT;
        ST_SV_WAIT: begin
          if (map_rdata) begin
            mark_q  <= sq_q;
            state_q <= ST_SV_MARK;
          end else begin
            base_q  <= base_q + MW'(1);
            sq_q    <= sq_next;
            state_q <= (sq_next > MaxWide) ? ST_IDLE : ST_SV_RD;
          end
        end
        // strike multiples of the base from its square upward
        ST_SV_MARK: begin
          if (mark_next > MaxWide) begin
            base_q  <= base_q + MW'(1);
            sq_q    <= sq_next;
            state_q <= (sq_next > MaxWide) ? ST_IDLE : ST_SV_RD;
          end else begin
            mark_q <= mark_next;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            cmd_q <= cmd_i;
            case (cmd_i.operation)
              OP_CLEAR:  count_q <= '0;
              OP_APPEND: if (count_q < DepthC) count_q <= count_q + CW'(1);
              OP_QUERY: begin
                lo_q    <= '0;
                hi_q    <= count_q;
                state_q <= ST_LO_REQ;
              end
              default: ;
            endcase
          end
        end
        // leftmost position not below range_low
        ST_LO_REQ: begin
          if (lo_q < hi_q) begin
            mid_q   <= mid_c;
            state_q <= ST_LO_CMP;
          end else begin
            first_q <= lo_q;
            lo_q    <= '0;
            hi_q    <= count_q;
            state_q <= ST_UP_REQ;
          end
        end
        ST_LO_CMP: begin
          if (st_rdata < cmd_q.range_low) lo_q <= mid_q + CW'(1);
          else hi_q <= mid_q;
          state_q <= ST_LO_REQ;
        end
        // first position above range_high
        ST_UP_REQ: begin
          if (lo_q < hi_q) begin
            mid_q   <= mid_c;
            state_q <= ST_UP_CMP;
          end else begin
            after_q <= lo_q;
            state_q <= ST_FL_LO;
          end
        end
        ST_UP_CMP: begin
          if (st_rdata <= cmd_q.range_high) lo_q <= mid_q + CW'(1);
          else hi_q <= mid_q;
          state_q <= ST_UP_REQ;
        end
        ST_FL_LO: state_q <= ST_FL_HI;
        ST_FL_HI: begin
          found_lo_q <= (first_q < count_q) && (st_rdata == cmd_q.range_low);
          state_q    <= ST_FL_CHK;
        end
        ST_FL_CHK: begin
          if (found_lo_q && (after_q != '0) && (st_rdata == cmd_q.range_high)) begin
            ptr_q    <= first_q;
            primes_q <= '0;
            s1_vld_q <= 1'b0;
            s2_vld_q <= 1'b0;
            state_q  <= ST_WALK;
          end else begin
            res_q   <= '0;
            rvld_q  <= 1'b1;
            state_q <= ST_IDLE;
          end
        end
        // stream the span: store read, then bitmap read, then tally
        ST_WALK: begin
          if (walk_issue) ptr_q <= ptr_q + CW'(1);
          s1_vld_q <= walk_issue;
          s2_vld_q <= s1_vld_q && elem_ok;
          if (s2_vld_q && map_rdata && (primes_q != COUNT_SAT)) begin
            primes_q <= primes_q + COUNT_W'(1);
          end
          if (!walk_issue && !s1_vld_q && !s2_vld_q) begin
            res_q.prime_count  <= primes_q;
            res_q.bounds_found <= 1'b1;
            rvld_q             <= 1'b1;
            state_q            <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy           = state_q != ST_IDLE;
  assign result_valid_o = rvld_q;
  assign result_o       = res_q;

endmodule

/* src/srpc_checker.sv */
module srpc_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input srpc_pkg::cmd_t cmd_i,
  input logic           result_valid_o,
  input srpc_pkg::res_t result_o
);

  import srpc_pkg::*;

  // a result only closes a query that kept the block busy
  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy))
    else $error("result without a running query");

  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("query gave more than one result");

  a_query_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && cmd_i.operation == OP_QUERY) |=> busy)
    else $error("accepted query did not raise busy");

  a_store_op_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (cmd_i.operation == OP_CLEAR || cmd_i.operation == OP_APPEND))
      |=> !busy && !result_valid_o)
    else $error("clear or append stalled or gave a result");

  a_missing_bound_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !result_o.bounds_found) |-> result_o.prime_count == '0)
    else $error("nonzero count with a missing bound");

endmodule

bind sorted_range_prime_counter srpc_checker u_srpc_checker (.*);

/* test/sorted_range_prime_counter_checker.sv */
module sorted_range_prime_counter_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  input  logic           busy,
  input  srpc_pkg::cmd_t cmd_i,
  input  logic           result_valid_o,
  input  srpc_pkg::res_t result_o,
  output int             fail_count,
  output int             pending_count
);
  import srpc_pkg::*;

  localparam int unsigned MAX_VAL = 65535;
  localparam int unsigned DEPTH   = 1024;

  bit          prime_bits [0:MAX_VAL];
  logic [15:0] stored     [0:DEPTH-1];
  int unsigned stored_cnt;
  res_t        expected_counts [$];

  initial begin
    fail_count    = 0;
    pending_count = 0;
    stored_cnt    = 0;
    for (int i = 0; i <= MAX_VAL; i++) prime_bits[i] = (i >= 2);
    for (int i = 2; i * i <= MAX_VAL; i++)
      if (prime_bits[i])
        for (int j = i * i; j <= MAX_VAL; j += i) prime_bits[j] = 0;
  end

  task automatic report(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    fail_count++;
  endtask

  // leftmost index whose element is not below v
  function automatic int unsigned first_not_below(input logic [15:0] v);
    int unsigned lo, hi, mid;
    lo = 0;
    hi = stored_cnt;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (stored[mid] < v) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  // leftmost index whose element is above v
  function automatic int unsigned first_above(input logic [15:0] v);
    int unsigned lo, hi, mid;
    lo = 0;
    hi = stored_cnt;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (stored[mid] <= v) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  function automatic res_t count_span(input logic [15:0] lo_v, input logic [15:0] hi_v);
    res_t        r;
    int unsigned s, a, n;
    bit          hit_lo, hit_hi;
    s = first_not_below(lo_v);
    a = first_above(hi_v);
    hit_lo = (s < stored_cnt) && (stored[s] == lo_v);
    hit_hi = (a > 0) && (stored[a-1] == hi_v);
    n = 0;
    if (hit_lo && hit_hi)
      for (int unsigned i = s; i < a; i++) n += prime_bits[stored[i]];
    if (n > COUNT_SAT) n = COUNT_SAT;
    r.prime_count  = n[COUNT_W-1:0];
    r.bounds_found = hit_lo && hit_hi;
    return r;
  endfunction

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni) begin
      if (start && !busy) begin
        case (cmd_i.operation)
          OP_CLEAR:  stored_cnt = 0;
          OP_APPEND: if (stored_cnt < DEPTH) begin
            stored[stored_cnt] = cmd_i.value;
            stored_cnt++;
          end
          OP_QUERY:  expected_counts.push_back(count_span(cmd_i.range_low, cmd_i.range_high));
          default: ;
        endcase
      end
      if (result_valid_o) begin
        if (expected_counts.size() == 0) begin
          report($sformatf("result %0d/%0b with nothing expected",
                           result_o.prime_count, result_o.bounds_found));
        end else begin
          want = expected_counts.pop_front();
          if (result_o.prime_count !== want.prime_count)
            report($sformatf("prime_count %0d, expected %0d",
                             result_o.prime_count, want.prime_count));
          if (result_o.bounds_found !== want.bounds_found)
            report($sformatf("bounds_found %0b, expected %0b",
                             result_o.bounds_found, want.bounds_found));
        end
      end
    end
    pending_count = expected_counts.size();
  end

endmodule

/* test/sorted_range_prime_counter_tb.sv */
module sorted_range_prime_counter_tb;
  import srpc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int unsigned ITEM_GOAL   = 580;

  logic           clk_i;
  logic           rst_ni;
  logic           start;
  logic           busy;
  cmd_t           cmd_i;
  logic           result_valid_o;
  res_t           result_o;
  int             fail_count;
  int             pending_count;
  int unsigned    cycles;
  int unsigned    items;
  bit             quiet;
  logic [15:0]    loaded [$];

  sorted_range_prime_counter u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  sorted_range_prime_counter_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .fail_count     (fail_count),
    .pending_count  (pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog: end the run if the block hangs
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Hold start and the command from a falling edge until a rising edge
  // sees busy low; return on the falling edge after the transfer.
  task automatic issue(input logic [1:0] op, input logic [15:0] v,
                       input logic [15:0] lo_v, input logic [15:0] hi_v);
    bit was_idle;
    while (!quiet && $urandom_range(0, 99) < 7) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start <= 1'b1;
    cmd_i <= '{operation: op, value: v, range_low: lo_v, range_high: hi_v};
    forever begin
      was_idle = !busy;
      @(negedge clk_i);
      if (was_idle) break;
    end
    items++;
    if (op == OP_CLEAR) loaded.delete();
    if (op == OP_APPEND && loaded.size() < 1024) loaded.push_back(v);
  endtask

  // Pick a bound: mostly a loaded value, sometimes a neighbor or noise.
  function automatic logic [15:0] pick_bound();
    int unsigned k;
    logic [15:0] v;
    if (loaded.size() == 0) return 16'($urandom);
    k = $urandom_range(0, 99);
    v = loaded[$urandom_range(0, loaded.size() - 1)];
    if (k < 80) return v;
    if (k < 90) return v + 16'd1;
    return 16'($urandom);
  endfunction

  task automatic load_sorted(input int unsigned n, input int unsigned spread);
    logic [16:0] v;
    v = 17'($urandom_range(0, 65535));
    if (v > 65535 - n * spread) v = 17'($urandom_range(0, 3));
    for (int unsigned i = 0; i < n; i++) begin
      issue(OP_APPEND, v[15:0], 16'($urandom), 16'($urandom));
      v = v + 17'($urandom_range(0, spread));
      if (v > 65535) v = 65535;
    end
  endtask

  task automatic ask(input int unsigned n);
    logic [15:0] a, b;
    for (int unsigned i = 0; i < n; i++) begin
      a = pick_bound();
      b = pick_bound();
      if ($urandom_range(0, 3) != 0 && a > b) issue(OP_QUERY, 16'($urandom), b, a);
      else issue(OP_QUERY, 16'($urandom), a, b);
    end
  endtask

  initial begin
    int unsigned kind;
    rst_ni = 1'b0;
    start  = 1'b0;
    cmd_i  = '0;
    cycles = 0;
    items  = 0;
    quiet  = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty store, extremes, duplicates, absent bounds, reversed span
    issue(OP_QUERY,  16'd0, 16'd0, 16'd0);
    issue(OP_APPEND, 16'd0, 16'hFFFF, 16'hFFFF);
    issue(OP_APPEND, 16'd1, 16'd0, 16'd0);
    issue(OP_APPEND, 16'd2, 16'd0, 16'd0);
    issue(OP_APPEND, 16'd2, 16'd0, 16'd0);
    issue(OP_APPEND, 16'd3, 16'd0, 16'd0);
    issue(OP_APPEND, 16'd65521, 16'd0, 16'd0);
    issue(OP_APPEND, 16'hFFFF, 16'd0, 16'd0);
    issue(OP_QUERY,  16'd0, 16'd0, 16'hFFFF);
    issue(OP_QUERY,  16'd0, 16'd2, 16'd2);
    issue(OP_QUERY,  16'd0, 16'd3, 16'd2);
    issue(OP_QUERY,  16'd0, 16'd4, 16'd65521);
    issue(OP_QUERY,  16'd0, 16'd0, 16'd5);
    issue(OP_QUERY,  16'hFFFF, 16'hFFFF, 16'hFFFF);
    issue(2'd3,      16'hFFFF, 16'hFFFF, 16'hFFFF);
    issue(OP_APPEND, 16'd5, 16'd0, 16'd0);
    issue(OP_QUERY,  16'd0, 16'd2, 16'd5);
    issue(OP_QUERY,  16'd0, 16'd1, 16'd65521);
    issue(OP_CLEAR,  16'hFFFF, 16'hFFFF, 16'hFFFF);
    issue(OP_QUERY,  16'd0, 16'd0, 16'd0);

    // random: mostly sorted loads followed by queries, some noise
    while (items < ITEM_GOAL) begin
      quiet = (items > 200 && items < 330);
      kind = $urandom_range(0, 99);
      if (kind < 85) begin
        issue(OP_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom));
        if ($urandom_range(0, 1)) load_sorted($urandom_range(1, 30), 3);
        else load_sorted($urandom_range(1, 30), 2000);
        ask($urandom_range(2, 8));
      end else begin
        repeat ($urandom_range(3, 10))
          issue(2'($urandom_range(0, 3)), 16'($urandom), pick_bound(), pick_bound());
      end
    end

    start <= 1'b0;
    while (pending_count != 0 || busy) @(negedge clk_i);
    repeat (50) @(posedge clk_i);
    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
